// ===== design/stopwatch_lap_recorder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Stopwatch lap recorder assertion macros
// Shared concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STOPWATCH_LAP_RECORDER_UNIT_DEFINES_SVH
`define STOPWATCH_LAP_RECORDER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define SLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stopwatch lap recorder: assertion failed");

`define SLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stopwatch lap recorder: assertion failed");

`else

`define SLR_ASSERT_NOW(lbl, ante, cons)

`define SLR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap recorder package
// Widths, event and status codes, controller states and command types.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int LAP_DEPTH = 16;
  localparam int LAP_AW    = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LAP_DEPTH + 1);
  localparam int IDX_W     = 4;
  localparam int TIME_W    = 40;
  localparam int ELAPSED_W = 32;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_START  = 3'd0,
    REQ_LAP    = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_STOP   = 3'd4,
    REQ_READ   = 3'd5
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOLAP = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic take;
    logic fetch;
    logic finish;
  } slr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic read_go;
  } slr_sts_t;

endpackage

// ===== design/slr_chan_if.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap recorder channels
// Request and response interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface slr_req_if import slr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TIME_W-1:0] now_time;
  logic [IDX_W-1:0]  lap_index;

  modport source (output valid, output req_type, output now_time, output lap_index,
                  input ready);
  modport sink   (input valid, input req_type, input now_time, input lap_index,
                  output ready);
endinterface

interface slr_rsp_if import slr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed;
  logic [STATUS_W-1:0]  status;
  logic [CNT_W-1:0]     laps_recorded;

  modport source (output valid, output elapsed, output status, output laps_recorded,
                  input ready);
  modport sink   (input valid, input elapsed, input status, input laps_recorded,
                  output ready);
endinterface

// ===== design/stopwatch_lap_recorder_unit.sv =====
// The response word is registered in the cycle after its request is taken; a recorded
// lap read passes FETCH and FINISH and reads the lap store twice via its single read
// port, taking no new word meanwhile. Throughput: one word per cycle when not stalled.
// Reset: asynchronous active low; clears base, pause, lap count and control state.
// The lap store is not cleared; entries are written before they are read.
// ----------------------------------------------------------------------------
// Stopwatch lap recorder top level
// Stopwatch with a lap store, built from a controller and a datapath.
// ----------------------------------------------------------------------------
`include "stopwatch_lap_recorder_unit_defines.svh"

module stopwatch_lap_recorder_unit import slr_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  slr_req_if.sink   req_i,
  slr_rsp_if.source rsp_o
);

  slr_cmd_t cmd;
  slr_sts_t sts;

  slr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .now_time_i      (req_i.now_time),
    .lap_index_i     (req_i.lap_index),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .elapsed_o       (rsp_o.elapsed),
    .status_o        (rsp_o.status),
    .laps_recorded_o (rsp_o.laps_recorded)
  );

  `SLR_ASSERT_NOW(a_ready_needs_slot, req_i.ready, !rsp_o.valid || rsp_o.ready)
  `SLR_ASSERT_NEXT(a_read_blocks, req_i.valid && req_i.ready && sts.read_go, !req_i.ready)
  `SLR_ASSERT_NOW(a_full_count, rsp_o.valid && rsp_o.status == ST_FULL, rsp_o.laps_recorded == CNT_W'(LAP_DEPTH))
  `SLR_ASSERT_NOW(a_nolap_zero, rsp_o.valid && rsp_o.status == ST_NOLAP, rsp_o.elapsed == '0)

endmodule

// ===== design/slr_ram.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap recorder RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module slr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/slr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap recorder controller
// Sequences acceptance, the two lap store reads and the response load.
// ----------------------------------------------------------------------------
module slr_ctrl import slr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  slr_sts_t sts_i,
  output slr_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.read_go) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      S_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== design/slr_datapath.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap recorder datapath
// Time registers, lap count, lap store and the response word register.
// ----------------------------------------------------------------------------
module slr_datapath import slr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slr_cmd_t             cmd_i,
  output slr_sts_t             sts_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [TIME_W-1:0]    now_time_i,
  input  logic [IDX_W-1:0]     lap_index_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [ELAPSED_W-1:0] elapsed_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [CNT_W-1:0]     laps_recorded_o
);

  logic [TIME_W-1:0]    base_q, base_d;
  logic [TIME_W-1:0]    pause_q, pause_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_W-1:0]    cur_q;
  logic                 out_valid_q;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [CNT_W-1:0]     laps_q;

  logic                 full;
  logic                 lap_we;
  logic                 ram_re;
  logic [LAP_AW-1:0]    ram_raddr;
  logic [TIME_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]    prev_time;
  logic [TIME_W-1:0]    stop_span;
  logic [TIME_W-1:0]    lap_span;

  assign full          = (cnt_q == CNT_W'(LAP_DEPTH));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.read_go  = (req_type_i == REQ_READ) && (CNT_W'(lap_index_i) < cnt_q);

  assign lap_we    = cmd_i.take && (req_type_i == REQ_LAP) && !full;
  assign ram_re    = (cmd_i.take && sts_o.read_go) || cmd_i.fetch;
  assign ram_raddr = cmd_i.fetch ? LAP_AW'(idx_q - IDX_W'(1)) : LAP_AW'(lap_index_i);

  slr_ram #(
    .WIDTH (TIME_W),
    .DEPTH (LAP_DEPTH)
  ) u_lap_store (
    .clk_i   (clk_i),
    .we_i    (lap_we),
    .waddr_i (cnt_q[LAP_AW-1:0]),
    .wdata_i (now_time_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stop_span = now_time_i - base_q;
  assign prev_time = (idx_q == '0) ? base_q : ram_rdata;
  assign lap_span  = cur_q - prev_time;

  always_comb begin
    base_d    = base_q;
    pause_d   = pause_q;
    cnt_d     = cnt_q;
    elapsed_d = '0;
    status_d  = ST_OK;
    case (req_type_i)
      REQ_START: begin
        base_d = now_time_i;
        cnt_d  = '0;
      end
      REQ_LAP: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      REQ_PAUSE: begin
        pause_d = now_time_i;
      end
      REQ_RESUME: begin
        base_d = base_q + (now_time_i - pause_q);
      end
      REQ_STOP: begin
        elapsed_d = stop_span[ELAPSED_W-1:0];
      end
      REQ_READ: begin
        status_d = ST_NOLAP;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      pause_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        base_q  <= base_d;
        pause_q <= pause_d;
        cnt_q   <= cnt_d;
      end
      if ((cmd_i.take && !sts_o.read_go) || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_q <= lap_index_i;
    end
    if (cmd_i.fetch) begin
      cur_q <= ram_rdata;
    end
    if (cmd_i.take && !sts_o.read_go) begin
      elapsed_q <= elapsed_d;
      status_q  <= status_d;
      laps_q    <= cnt_d;
    end else if (cmd_i.finish) begin
      elapsed_q <= lap_span[ELAPSED_W-1:0];
      status_q  <= ST_OK;
      laps_q    <= cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign elapsed_o       = elapsed_q;
  assign status_o        = status_q;
  assign laps_recorded_o = laps_q;

endmodule

// ===== bench/slr_lap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch lap recorder checker
// Watches the request and response channels, and predicts every response word
// from its own copy of the base, pause and lap times. It compares each
// accepted response word with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module slr_lap_checker import slr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  slr_req_if   req_i,
  slr_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     laps;
  } lap_result_t;

  logic [TIME_W-1:0] base_time_q;
  logic [TIME_W-1:0] pause_time_q;
  logic [TIME_W-1:0] lap_times_q [LAP_DEPTH];
  logic [CNT_W-1:0]  lap_count_q;
  lap_result_t       awaited_q [$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < 100) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
    mismatches++;
  endtask

  function automatic lap_result_t predict_lap_result(input logic [REQ_W-1:0] kind,
                                                     input logic [TIME_W-1:0] now,
                                                     input logic [IDX_W-1:0] idx);
    lap_result_t       res;
    logic [TIME_W-1:0] prev;
    logic [TIME_W-1:0] span;
    res.elapsed = '0;
    res.status  = ST_OK;
    case (kind)
      REQ_START: begin
        base_time_q = now;
        lap_count_q = '0;
      end
      REQ_LAP: begin
        if (lap_count_q < CNT_W'(LAP_DEPTH)) begin
          lap_times_q[lap_count_q] = now;
          lap_count_q = lap_count_q + CNT_W'(1);
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_PAUSE: begin
        pause_time_q = now;
      end
      REQ_RESUME: begin
        base_time_q = base_time_q + (now - pause_time_q);
      end
      REQ_STOP: begin
        span = now - base_time_q;
        res.elapsed = span[ELAPSED_W-1:0];
      end
      REQ_READ: begin
        if (CNT_W'(idx) < lap_count_q) begin
          prev = (idx == '0) ? base_time_q : lap_times_q[idx - IDX_W'(1)];
          span = lap_times_q[idx] - prev;
          res.elapsed = span[ELAPSED_W-1:0];
        end else begin
          res.status = ST_NOLAP;
        end
      end
      default: begin
      end
    endcase
    res.laps = lap_count_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lap_result_t want;
    if (!rst_ni) begin
      base_time_q  = '0;
      pause_time_q = '0;
      lap_count_q  = '0;
      awaited_q.delete();
      pending_o    = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected word", '0, 64'(rsp_i.elapsed));
        end else begin
          want = awaited_q.pop_front();
          if (rsp_i.elapsed !== want.elapsed) begin
            report_mismatch("elapsed", 64'(want.elapsed), 64'(rsp_i.elapsed));
          end
          if (rsp_i.status !== want.status) begin
            report_mismatch("status", 64'(want.status), 64'(rsp_i.status));
          end
          if (rsp_i.laps_recorded !== want.laps) begin
            report_mismatch("laps_recorded", 64'(want.laps), 64'(rsp_i.laps_recorded));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_q.push_back(predict_lap_result(req_i.req_type, req_i.now_time,
                                               req_i.lap_index));
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch lap recorder testbench
// Drives directed and random event words through the request channel under
// several idle and stall patterns, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import slr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RSVD_A   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B   = 3'd7;
  localparam int               PHASE_ITEMS  = 150;
  localparam int               DRAIN_CYCLES = 6;
  localparam int               CYCLE_LIMIT  = 300000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   items_sent = 0;
  int   laps_sent = 0;

  slr_req_if req_if ();
  slr_rsp_if rsp_if ();

  stopwatch_lap_recorder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  slr_lap_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] now,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.now_time  <= now;
    req_if.lap_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    if (kind == REQ_START) begin
      laps_sent = 0;
    end else if (kind == REQ_LAP && laps_sent < LAP_DEPTH) begin
      laps_sent++;
    end
  endtask

  task automatic drain_results(input int settle);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic run_session();
    logic [TIME_W-1:0] now;
    logic [REQ_W-1:0]  kind;
    logic [IDX_W-1:0]  idx;
    int                len;
    int                pick;
    now = TIME_W'({$urandom, $urandom});
    send_word(REQ_START, now, IDX_W'($urandom));
    len = $urandom_range(4, 40);
    repeat (len) begin
      if ($urandom_range(9) == 0) begin
        now = now + TIME_W'({$urandom, $urandom});
      end else begin
        now = now + TIME_W'($urandom_range(1, 5000));
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        kind = REQ_LAP;
      end else if (pick < 47) begin
        kind = REQ_PAUSE;
      end else if (pick < 60) begin
        kind = REQ_RESUME;
      end else if (pick < 72) begin
        kind = REQ_STOP;
      end else begin
        kind = REQ_READ;
      end
      if (kind == REQ_READ && laps_sent > 0 && $urandom_range(3) != 0) begin
        idx = IDX_W'($urandom_range(laps_sent - 1));
      end else begin
        idx = IDX_W'($urandom);
      end
      send_word(kind, now, idx);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int first;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        send_word(REQ_W'($urandom_range(7)), TIME_W'({$urandom, $urandom}),
                  IDX_W'($urandom));
      end else begin
        run_session();
      end
    end
    drain_results(DRAIN_CYCLES);
  endtask

  initial begin
    logic [TIME_W-1:0] now;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = '0;
    req_if.now_time  = '0;
    req_if.lap_index = '0;
    rsp_if.ready     = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_word(REQ_READ, '0, '0);
    send_word(REQ_RSVD_A, '1, '1);
    send_word(REQ_RSVD_B, '0, '0);
    send_word(REQ_RESUME, 40'h00_0000_1234, '0);
    send_word(REQ_STOP, 40'hFF_FFFF_FFFF, '1);
    send_word(REQ_START, 40'hFF_FFFF_FF00, '0);
    send_word(REQ_PAUSE, 40'hFF_FFFF_FF10, '0);
    send_word(REQ_PAUSE, 40'hFF_FFFF_FF20, '0);
    send_word(REQ_RESUME, 40'h00_0000_0020, '0);
    now = 40'h00_0000_0100;
    for (int i = 0; i < LAP_DEPTH; i++) begin
      now = now + 40'h0_8000_0003 * TIME_W'(i + 1);
      send_word(REQ_LAP, now, IDX_W'(~i));
    end
    send_word(REQ_LAP, now + 40'h10, '0);
    send_word(REQ_READ, now, 4'd0);
    send_word(REQ_READ, now, 4'd15);
    drain_results(DRAIN_CYCLES);

    run_phase(0, 0);
    run_phase(70, 0);
    run_phase(0, 70);
    run_phase(12, 12);

    drain_results(10);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/slr_pkg.sv
design/slr_chan_if.sv
design/slr_ram.sv
design/slr_ctrl.sv
design/slr_datapath.sv
design/stopwatch_lap_recorder_unit.sv
bench/slr_lap_checker.sv
bench/tb_top.sv
